FILE: rtl/ihi_pkg.sv
package ihi_pkg;

	localparam int HDR_IDX_W = 5;

	localparam logic [0:0] OP_START   = 1'b0;
	localparam logic [0:0] OP_PAYLOAD = 1'b1;

	localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = 5'd19;
	localparam logic [15:0] HDR_BYTES   = 16'd20;
	localparam logic [15:0] MAX_PAYLOAD = 16'd65515;

	localparam logic [7:0]  VER_IHL     = 8'h45;
	localparam logic [7:0]  TOS         = 8'h00;
	localparam logic [15:0] IP_ID       = 16'hFFFF;
	localparam logic [15:0] FLAGS_DF    = 16'h4000;
	localparam logic [7:0]  IP_TTL      = 8'd64;

	typedef struct packed {
		logic [0:0]  op;
		logic [31:0] dest_addr;
		logic [7:0]  protocol_number;
		logic [15:0] payload_length;
		logic [7:0]  payload_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_header;
		logic       out_last;
	} out_item_t;

	typedef struct packed {
		logic [15:0] total;
		logic [7:0]  proto;
		logic [31:0] src;
		logic [31:0] dst;
	} hdr_fields_t;

endpackage

FILE: rtl/ihi_csum.sv
module ihi_csum
	import ihi_pkg::*;
(
	input  hdr_fields_t fields,
	output logic [15:0] cks
);

	logic [19:0] sum;
	logic [16:0] fold1;
	logic [15:0] fold2;

	always_comb begin
		sum = 20'({VER_IHL, TOS}) + 20'(fields.total) + 20'(IP_ID) + 20'(FLAGS_DF)
			+ 20'({IP_TTL, fields.proto})
			+ 20'(fields.src[31:16]) + 20'(fields.src[15:0])
			+ 20'(fields.dst[31:16]) + 20'(fields.dst[15:0]);
		// two end-around folds cover a 20-bit sum
		fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
		fold2 = fold1[15:0] + 16'(fold1[16]);
		cks   = ~fold2;
	end

endmodule

FILE: rtl/ihi_hdr_sel.sv
module ihi_hdr_sel
	import ihi_pkg::*;
(
	input  hdr_fields_t          fields,
	input  logic [15:0]          cks,
	input  logic [HDR_IDX_W-1:0] idx,
	output logic [7:0]           hdr_byte
);

	always_comb begin
		case (idx)
			5'd0:    hdr_byte = VER_IHL;
			5'd1:    hdr_byte = TOS;
			5'd2:    hdr_byte = fields.total[15:8];
			5'd3:    hdr_byte = fields.total[7:0];
			5'd4:    hdr_byte = IP_ID[15:8];
			5'd5:    hdr_byte = IP_ID[7:0];
			5'd6:    hdr_byte = FLAGS_DF[15:8];
			5'd7:    hdr_byte = FLAGS_DF[7:0];
			5'd8:    hdr_byte = IP_TTL;
			5'd9:    hdr_byte = fields.proto;
			5'd10:   hdr_byte = cks[15:8];
			5'd11:   hdr_byte = cks[7:0];
			5'd12:   hdr_byte = fields.src[31:24];
			5'd13:   hdr_byte = fields.src[23:16];
			5'd14:   hdr_byte = fields.src[15:8];
			5'd15:   hdr_byte = fields.src[7:0];
			5'd16:   hdr_byte = fields.dst[31:24];
			5'd17:   hdr_byte = fields.dst[23:16];
			5'd18:   hdr_byte = fields.dst[15:8];
			5'd19:   hdr_byte = fields.dst[7:0];
			default: hdr_byte = 8'h00;
		endcase
	end

endmodule

FILE: rtl/ipv4_header_inserter.sv
// IPv4 header inserter.
// Input channel (in_valid / in_stall / in_item): a start beat (op = 0) carries the
// destination, protocol and payload length; a payload beat (op = 1) carries one byte.
// Output channel (out_valid / out_stall / out_item): the packet as bytes in wire
// order, is_header on the 20 header bytes, out_last on the final byte of a packet.
// cfg_we / cfg_wdata write the source address; write only while the block is idle.
// Path: a beat is registered on accept; a payload byte then goes to the output register,
// and a start beat first loads the header field and checksum registers.
// Throughput: payload bytes pass at one per cycle while the receiver does not stall.
// A start beat occupies the output for its 20 header bytes (one header byte per cycle
// from the header serializer when not stalled), and the output goes empty before them
// when it follows a payload byte; later beats wait in the input register meanwhile.
// Payload beats outside a packet are dropped. A start during an open packet
// abandons it without a last mark.
// Reset clears all valid flags and packet state and sets the source address to 0.
// When the receiver stalls, the output register holds its beat and the input
// register fills, then in_stall rises; no beat is lost.
module ipv4_header_inserter
	import ihi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	logic                 valid_s1;
	in_item_t             item_s1;
	logic [31:0]          src_q;
	logic [15:0]          rem_q;
	logic                 packet_open_q;
	logic                 hdr_busy_q;
	logic [HDR_IDX_W-1:0] hdr_idx_q;
	hdr_fields_t          hdr_q;
	logic [15:0]          cks_q;
	logic                 hdr_last_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic        out_load_ok;
	logic        hdr_emit;
	logic        hdr_done;
	logic        is_start;
	logic        pay_fwd;
	logic        adv_s1;
	logic [15:0] sat_len;
	hdr_fields_t new_fields;
	logic [15:0] new_cks;
	logic [7:0]  hdr_byte;

	always_comb begin
		out_load_ok = !out_valid_q || !out_stall;
		hdr_emit    = hdr_busy_q && out_load_ok;
		hdr_done    = hdr_emit && (hdr_idx_q == HDR_LAST_IDX);
		is_start    = item_s1.op == OP_START;
		pay_fwd     = packet_open_q && (rem_q != 16'd0);
		if (is_start)
			adv_s1 = valid_s1 && (!hdr_busy_q || hdr_done);
		else
			adv_s1 = valid_s1 && !hdr_busy_q && (!pay_fwd || out_load_ok);
		sat_len = (item_s1.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD
			: item_s1.payload_length;
		new_fields.total = sat_len + HDR_BYTES;
		new_fields.proto = item_s1.protocol_number;
		new_fields.src   = src_q;
		new_fields.dst   = item_s1.dest_addr;
	end

	assign in_stall  = valid_s1 && !adv_s1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	ihi_csum u_csum (
		.fields (new_fields),
		.cks    (new_cks)
	);

	ihi_hdr_sel u_hdr_sel (
		.fields   (hdr_q),
		.cks      (cks_q),
		.idx      (hdr_idx_q),
		.hdr_byte (hdr_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= '0;
		end else if (cfg_we) begin
			src_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			item_s1 <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q         <= '0;
			packet_open_q <= 1'b0;
			hdr_busy_q    <= 1'b0;
			hdr_idx_q     <= '0;
		end else begin
			if (adv_s1 && is_start) begin
				rem_q         <= sat_len;
				packet_open_q <= sat_len != 16'd0;
			end else if (adv_s1) begin
				if (pay_fwd) begin
					rem_q         <= rem_q - 16'd1;
					packet_open_q <= rem_q != 16'd1;
				end else begin
					packet_open_q <= 1'b0;
				end
			end
			if (adv_s1 && is_start) begin
				hdr_busy_q <= 1'b1;
				hdr_idx_q  <= '0;
			end else if (hdr_emit) begin
				hdr_busy_q <= !hdr_done;
				hdr_idx_q  <= hdr_idx_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && is_start) begin
			hdr_q      <= new_fields;
			cks_q      <= new_cks;
			hdr_last_q <= sat_len == 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (hdr_emit || (adv_s1 && !is_start && pay_fwd)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_emit) begin
			out_q.out_byte  <= hdr_byte;
			out_q.is_header <= 1'b1;
			out_q.out_last  <= hdr_last_q && (hdr_idx_q == HDR_LAST_IDX);
		end else if (adv_s1 && !is_start && pay_fwd) begin
			out_q.out_byte  <= item_s1.payload_byte;
			out_q.is_header <= 1'b0;
			out_q.out_last  <= rem_q == 16'd1;
		end
	end

`ifndef ASSERT_OFF
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_busy_q |-> hdr_idx_q <= HDR_LAST_IDX)
		else $error("header index out of range");

	a_open_rem: assert property (@(posedge clk) disable iff (!arst_n)
		packet_open_q |-> rem_q != 16'd0)
		else $error("open packet with no bytes remaining");

	a_pay_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.op == OP_PAYLOAD && hdr_busy_q) |-> in_stall)
		else $error("payload beat passed during header");

	a_hdr_load: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_emit |=> out_valid_q && out_q.is_header)
		else $error("header byte not loaded to output");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ihi_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 12;
	localparam logic [15:0] LEN_CAP = 16'd65515;
	localparam logic [15:0] HDR_LEN = 16'd20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	in_item_t    beats_to_send[$];
	out_item_t   exp_wire_bytes[$];
	out_item_t   want_byte;
	logic [31:0] own_addr = '0;
	logic [15:0] bytes_left = '0;
	logic        pkt_open = 1'b0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          errors = 0;
	int          quiet_cycles = 0;

	ipv4_header_inserter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial forever #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic predict_packet_bytes(input in_item_t b);
		logic [15:0]  len;
		logic [15:0]  total;
		logic [31:0]  acc;
		logic [159:0] hdr;
		out_item_t    r;
		if (b.op == OP_START) begin
			len = (b.payload_length > LEN_CAP) ? LEN_CAP : b.payload_length;
			total = len + HDR_LEN;
			// checksum word zero while summing
			hdr = {8'h45, 8'h00, total, 16'hFFFF, 16'h4000, 8'd64, b.protocol_number,
				16'h0000, own_addr, b.dest_addr};
			acc = '0;
			for (int i = 0; i < 10; i++)
				acc = acc + {16'h0000, hdr[159-16*i -: 16]};
			while (acc[31:16] != 16'h0000)
				acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
			hdr[79:64] = ~acc[15:0];
			for (int i = 0; i < 20; i++) begin
				r.out_byte = hdr[159-8*i -: 8];
				r.is_header = 1'b1;
				r.out_last = (len == 16'd0) && (i == 19);
				exp_wire_bytes.push_back(r);
			end
			bytes_left = len;
			pkt_open = (len != 16'd0);
		end else if (!pkt_open || bytes_left == 16'd0) begin
			pkt_open = 1'b0;
		end else begin
			bytes_left = bytes_left - 16'd1;
			r.out_byte = b.payload_byte;
			r.is_header = 1'b0;
			r.out_last = (bytes_left == 16'd0);
			exp_wire_bytes.push_back(r);
			if (bytes_left == 16'd0)
				pkt_open = 1'b0;
		end
	endtask

	// unused fields carry random noise
	function automatic in_item_t noisy_item();
		in_item_t b;
		b.op = OP_PAYLOAD;
		b.dest_addr = $urandom();
		b.protocol_number = 8'($urandom());
		b.payload_length = 16'($urandom());
		b.payload_byte = 8'($urandom());
		return b;
	endfunction

	task automatic push_start(input logic [31:0] dst, input logic [7:0] proto,
			input logic [15:0] len);
		in_item_t b;
		b = noisy_item();
		b.op = OP_START;
		b.dest_addr = dst;
		b.protocol_number = proto;
		b.payload_length = len;
		beats_to_send.push_back(b);
	endtask

	task automatic push_payload(input logic [7:0] data);
		in_item_t b;
		b = noisy_item();
		b.op = OP_PAYLOAD;
		b.payload_byte = data;
		beats_to_send.push_back(b);
	endtask

	task automatic push_directed();
		push_payload(8'h5A);
		push_start(32'h0000_0000, 8'h00, 16'd0);
		push_start(32'hFFFF_FFFF, 8'hFF, 16'd3);
		push_payload(8'h00);
		push_payload(8'hFF);
		push_payload(8'hA5);
		push_payload(8'h3C);
		push_start(32'hC0A8_0001, 8'd6, 16'hFFFF);
		push_payload(8'h11);
		push_payload(8'h22);
		push_start(32'h0A00_0001, 8'd17, LEN_CAP);
		push_payload(8'h33);
		push_start($urandom(), 8'd1, 16'd65516);
		push_start(32'h7F00_0001, 8'h11, 16'd1);
		push_payload(8'h80);
		push_payload(8'h81);
		push_start(32'h8000_0000, 8'h80, 16'd2);
		push_payload(8'h01);
		push_payload(8'hFE);
	endtask

	task automatic push_random(input int n);
		int count;
		int kind;
		int nb;
		logic [15:0] len;
		count = 0;
		while (count < n) begin
			kind = int'($urandom_range(99));
			if (kind < 8) begin
				push_payload(8'($urandom()));
				count++;
			end else begin
				len = (kind < 16) ? 16'($urandom()) : 16'($urandom_range(7));
				push_start($urandom(), 8'($urandom()), len);
				if (len > 16'd8)
					nb = int'($urandom_range(4));
				else if (kind < 24)
					nb = int'($urandom_range(int'(len)));
				else if (kind < 32)
					nb = int'(len) + 2;
				else
					nb = int'(len);
				for (int i = 0; i < nb; i++)
					push_payload(8'($urandom()));
				count += 1 + nb;
			end
		end
	endtask

	task automatic drain();
		do @(negedge clk);
		while (beats_to_send.size() != 0 || in_valid || exp_wire_bytes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input bit write_cfg,
			input logic [31:0] addr, input bit directed, input int n);
		if (write_cfg) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_wdata <= addr;
			@(posedge clk);
			cfg_we <= 1'b0;
			own_addr = addr;
		end
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		@(negedge clk);
		if (directed)
			push_directed();
		push_random(n);
		drain();
	endtask

	always @(posedge clk) begin
		if (in_valid && !in_stall)
			predict_packet_bytes(in_item);
		if (!in_valid || !in_stall) begin
			if (beats_to_send.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_item <= beats_to_send.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= (int'($urandom_range(99)) < recv_stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (exp_wire_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected beat %02h", out_item.out_byte));
			end else begin
				want_byte = exp_wire_bytes.pop_front();
				if (out_item.out_byte !== want_byte.out_byte)
					report_mismatch($sformatf("out_byte %02h, want %02h",
						out_item.out_byte, want_byte.out_byte));
				if (out_item.is_header !== want_byte.is_header)
					report_mismatch($sformatf("is_header %b, want %b",
						out_item.is_header, want_byte.is_header));
				if (out_item.out_last !== want_byte.out_last)
					report_mismatch($sformatf("out_last %b, want %b",
						out_item.out_last, want_byte.out_last));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(!in_valid && beats_to_send.size() == 0 && exp_wire_bytes.size() == 0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		run_phase(0, 0, 1'b0, 32'h0000_0000, 1'b1, 20);
		run_phase(62, 0, 1'b1, 32'hFFFF_FFFF, 1'b0, 20);
		run_phase(0, 62, 1'b1, $urandom(), 1'b0, 20);
		run_phase(16, 16, 1'b1, 32'h0000_0000, 1'b0, 20);
		run_phase(0, 0, 1'b1, $urandom(), 1'b0, 20);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: ipv4_header_inserter.f
rtl/ihi_pkg.sv
rtl/ihi_csum.sv
rtl/ihi_hdr_sel.sv
rtl/ipv4_header_inserter.sv
tb/tb_top.sv
